// ----- design/bfc_pkg.sv -----
// Shared types, constants and the CRC byte update for the bus frame checker.
package bfc_pkg;

   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned CRC_HDR_SPAN = 6;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP = 16'h8000;

   localparam logic CSR_MAGIC_FIRST = 1'b0;
   localparam logic CSR_MAGIC_SECOND = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_MAGIC = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_CRC       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PAYLOAD,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic       is_status;
      logic [7:0] payload_byte;
      logic [7:0] node_id;
      logic [7:0] command;
      logic [5:0] payload_length;
      status_type status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      status_type status;
      logic [7:0] node;
      logic [7:0] command;
      logic [5:0] length;
      logic       bank;
   } job_type;

   typedef struct packed {
      logic       en;
      logic       bank;
      logic [5:0] idx;
      logic [7:0] data;
   } mem_wr_type;

   // CRC16/CCITT-FALSE update by one byte, MSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- design/bfc_front.sv -----
// Front end: tracks frame position, runs the CRC, stores payload and judges each frame.
module bfc_front #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 32,
   parameter int unsigned FRAME_BYTES = 40
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  bfc_pkg::req_type    req,
   input  logic [7:0]          magic_first,
   input  logic [7:0]          magic_second,
   output logic                job_push,
   output bfc_pkg::job_type    job,
   output bfc_pkg::mem_wr_type mem_wr
);

   localparam int unsigned LIMIT = (FRAME_BYTES - bfc_pkg::HDR_BYTES < MAX_PAYLOAD_BYTES) ?
                                   (FRAME_BYTES - bfc_pkg::HDR_BYTES) : MAX_PAYLOAD_BYTES;

   localparam logic [5:0] POS_MAGIC_0 = 6'd0;
   localparam logic [5:0] POS_MAGIC_1 = 6'd1;
   localparam logic [5:0] POS_NODE    = 6'd2;
   localparam logic [5:0] POS_CMD     = 6'd3;
   localparam logic [5:0] POS_LEN_LO  = 6'd4;
   localparam logic [5:0] POS_LEN_HI  = 6'd5;
   localparam logic [5:0] POS_CRC_LO  = 6'd6;
   localparam logic [5:0] POS_CRC_HI  = 6'd7;

   logic [5:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        magic_good_ff, magic_good_in;
   logic [7:0]  node_ff, node_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] raw_len_ff, raw_len_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic        wbank_ff, wbank_in;

   logic [5:0]  pos;
   logic [5:0]  pl_idx;
   logic        in_payload;
   logic        feed_crc;
   logic [15:0] crc_step;
   logic        end_byte;

   always_comb begin
      pos        = req.frame_start ? POS_MAGIC_0 : pos_ff;
      pl_idx     = pos - 6'(bfc_pkg::HDR_BYTES);
      in_payload = pos >= 6'(bfc_pkg::HDR_BYTES);
      feed_crc   = (pos < 6'(bfc_pkg::CRC_HDR_SPAN)) ||
                   (in_payload && ({10'd0, pl_idx} < raw_len_ff));
      crc_step   = bfc_pkg::crc_feed((pos == POS_MAGIC_0) ? bfc_pkg::CRC_INIT : crc_ff,
                                     req.data_byte);
      end_byte   = pos >= 6'(FRAME_BYTES - 1);

      crc_in        = crc_ff;
      magic_good_in = magic_good_ff;
      node_in       = node_ff;
      cmd_in        = cmd_ff;
      raw_len_in    = raw_len_ff;
      rx_crc_in     = rx_crc_ff;

      if (feed_crc) begin
         crc_in = crc_step;
      end
      case (pos)
         POS_MAGIC_0: begin
            magic_good_in = (req.data_byte == magic_first);
         end
         POS_MAGIC_1: begin
            magic_good_in = magic_good_ff && (req.data_byte == magic_second);
         end
         POS_NODE:   node_in = req.data_byte;
         POS_CMD:    cmd_in = req.data_byte;
         POS_LEN_LO: raw_len_in = {raw_len_ff[15:8], req.data_byte};
         POS_LEN_HI: raw_len_in = {req.data_byte, raw_len_ff[7:0]};
         POS_CRC_LO: rx_crc_in = {rx_crc_ff[15:8], req.data_byte};
         POS_CRC_HI: rx_crc_in = {req.data_byte, rx_crc_ff[7:0]};
         default: ;
      endcase

      pos_in   = end_byte ? POS_MAGIC_0 : pos + 6'd1;
      wbank_in = end_byte ? ~wbank_ff : wbank_ff;

      // Judge with the values this byte leaves behind.
      job.node    = node_in;
      job.command = cmd_in;
      job.length  = raw_len_in[5:0];
      job.bank    = wbank_ff;
      if (!magic_good_in) begin
         job.status = bfc_pkg::ST_BAD_MAGIC;
      end else if (raw_len_in > 16'(LIMIT)) begin
         job.status = bfc_pkg::ST_OVERFLOW;
      end else if (crc_in != rx_crc_in) begin
         job.status = bfc_pkg::ST_CRC;
      end else begin
         job.status = bfc_pkg::ST_OK;
      end
      job_push = accept && end_byte;

      mem_wr.en   = accept && in_payload && (pl_idx < 6'(MAX_PAYLOAD_BYTES));
      mem_wr.bank = wbank_ff;
      mem_wr.idx  = pl_idx;
      mem_wr.data = req.data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 6'd0;
         crc_ff        <= bfc_pkg::CRC_INIT;
         magic_good_ff <= 1'b1;
         node_ff       <= 8'd0;
         cmd_ff        <= 8'd0;
         raw_len_ff    <= 16'd0;
         rx_crc_ff     <= 16'd0;
         wbank_ff      <= 1'b0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         magic_good_ff <= magic_good_in;
         node_ff       <= node_in;
         cmd_ff        <= cmd_in;
         raw_len_ff    <= raw_len_in;
         rx_crc_ff     <= rx_crc_in;
         wbank_ff      <= wbank_in;
      end
   end

endmodule

// ----- design/bfc_job_fifo.sv -----
// Two-entry queue of judged frames between the front and back ends.
module bfc_job_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bfc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output bfc_pkg::job_type head
);

   bfc_pkg::job_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full     = count_ff == 2'd2;
      empty    = count_ff == 2'd0;
      head     = slot_ff[rptr_ff];
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/bfc_back.sv -----
// Back end: payload memory, delivery sequencer and the result queue.
module bfc_back #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  bfc_pkg::mem_wr_type mem_wr,
   input  logic                job_valid,
   input  bfc_pkg::job_type    job,
   output logic                job_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output bfc_pkg::rsp_type    rsp_data
);

   localparam int unsigned IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
   localparam int unsigned OQ_DEPTH = 4;

   logic [7:0] mem [2][MAX_PAYLOAD_BYTES];
   logic [7:0] rd_data_ff;

   bfc_pkg::back_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_idx;
   logic             room;
   logic             issue_rd, issue_st;

   logic             stg_valid_ff, stg_valid_in;
   logic             stg_status_ff;
   bfc_pkg::job_type stg_job_ff;
   bfc_pkg::rsp_type stg_item;

   bfc_pkg::rsp_type oq_ff [OQ_DEPTH];
   logic [1:0] oq_wptr_ff, oq_rptr_ff;
   logic [2:0] oq_count_ff, oq_count_in;
   logic       oq_pop;

   // Keep a slot free for whatever is already in the read stage.
   assign room     = (oq_count_ff + {2'd0, stg_valid_ff}) < 3'd3;
   assign last_idx = 6'(idx_ff) == (job.length - 6'd1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfc_pkg::BK_IDLE: begin
            if (job_valid) begin
               if (job.status == bfc_pkg::ST_OK && job.length != 6'd0) begin
                  state_in = bfc_pkg::BK_PAYLOAD;
               end else begin
                  state_in = bfc_pkg::BK_STATUS;
               end
            end
         end
         bfc_pkg::BK_PAYLOAD: begin
            if (room && last_idx) begin
               state_in = bfc_pkg::BK_STATUS;
            end
         end
         bfc_pkg::BK_STATUS: begin
            if (room) begin
               state_in = bfc_pkg::BK_IDLE;
            end
         end
         default: state_in = bfc_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      issue_rd = 1'b0;
      issue_st = 1'b0;
      idx_in   = idx_ff;
      case (state_ff)
         bfc_pkg::BK_IDLE: idx_in = '0;
         bfc_pkg::BK_PAYLOAD: begin
            issue_rd = room;
            if (room) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         bfc_pkg::BK_STATUS: issue_st = room;
         default: ;
      endcase
      job_pop      = issue_st;
      stg_valid_in = issue_rd || issue_st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfc_pkg::BK_IDLE;
         idx_ff       <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_valid_in) begin
         stg_status_ff <= issue_st;
         stg_job_ff    <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.bank][mem_wr.idx[IDX_W-1:0]] <= mem_wr.data;
      end
      if (issue_rd) begin
         rd_data_ff <= mem[job.bank][idx_ff];
      end
   end

   always_comb begin
      stg_item.is_status = stg_status_ff;
      stg_item.last      = stg_status_ff;
      stg_item.status    = stg_job_ff.status;
      if (stg_job_ff.status == bfc_pkg::ST_OK) begin
         stg_item.node_id        = stg_job_ff.node;
         stg_item.command        = stg_job_ff.command;
         stg_item.payload_length = stg_job_ff.length;
      end else begin
         stg_item.node_id        = 8'd0;
         stg_item.command        = 8'd0;
         stg_item.payload_length = 6'd0;
      end
      stg_item.payload_byte = stg_status_ff ? 8'd0 : rd_data_ff;
   end

   assign rsp_empty   = oq_count_ff == 3'd0;
   assign rsp_data    = oq_ff[oq_rptr_ff];
   assign oq_pop      = rsp_pop && !rsp_empty;
   assign oq_count_in = oq_count_ff + {2'd0, stg_valid_ff} - {2'd0, oq_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wptr_ff  <= 2'd0;
         oq_rptr_ff  <= 2'd0;
         oq_count_ff <= 3'd0;
      end else begin
         if (stg_valid_ff) begin
            oq_wptr_ff <= oq_wptr_ff + 2'd1;
         end
         if (oq_pop) begin
            oq_rptr_ff <= oq_rptr_ff + 2'd1;
         end
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_valid_ff) begin
         oq_ff[oq_wptr_ff] <= stg_item;
      end
   end

endmodule

// ----- design/bus_frame_checker_top.sv -----
// Top level of the bus frame checker: CSRs, front end, frame queue and back end.
//
// Usage:
//   Requests carry one wire byte of a fixed-size frame on req_data; push a
//   request while req_full is low. frame_start marks byte zero and
//   resynchronises the position; after the last frame byte the next request
//   is byte zero again. Bytes that do not end a frame produce no result.
//   On the last frame byte the frame is judged in the same cycle. A good
//   frame delivers its payload bytes and then a status item (last high);
//   a bad one delivers one status item with the first error found.
//   Results queue up on rsp_data; take one with rsp_pop while rsp_empty is low.
//   A frame's first result passes frame queue, back-end state, read stage and
//   result queue; then one per cycle while rsp_pop is high and rsp_empty low.
//   Throughput: one request per cycle; the two-entry frame queue and the
//   double-banked payload memory let the next frame stream in while the
//   previous one drains, so req_full only rises when two judged frames wait.
//   Write magic_first/magic_second via csr_we/csr_index/csr_wdata when idle.
//   Reset (synchronous) empties all queues and clears both magic registers.
//   If the receiver stalls, results hold and req_full eventually backs up.
module bus_frame_checker_top #(
   parameter int unsigned MAX_PAYLOAD_BYTES = 32,
   parameter int unsigned FRAME_BYTES = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  bfc_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bfc_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   logic [7:0] magic_first_ff;
   logic [7:0] magic_second_ff;

   logic                accept;
   logic                job_push;
   logic                job_pop;
   logic                job_full;
   logic                job_empty;
   bfc_pkg::job_type    new_job;
   bfc_pkg::job_type    head_job;
   bfc_pkg::mem_wr_type mem_wr;

   // Hold new requests while both payload banks belong to waiting frames.
   assign req_full = job_full;
   assign accept   = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff  <= 8'd0;
         magic_second_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            bfc_pkg::CSR_MAGIC_FIRST:  magic_first_ff <= csr_wdata;
            bfc_pkg::CSR_MAGIC_SECOND: magic_second_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify bytes and judge each frame as its last byte arrives.
   bfc_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .magic_first (magic_first_ff),
      .magic_second(magic_second_ff),
      .job_push    (job_push),
      .job         (new_job),
      .mem_wr      (mem_wr)
   );

   // Decouple judging from delivery.
   bfc_job_fifo u_job_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .push_job(new_job),
      .pop     (job_pop),
      .full    (job_full),
      .empty   (job_empty),
      .head    (head_job)
   );

   // Drain payload bytes from the frame's bank, then the status item.
   bfc_back #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mem_wr   (mem_wr),
      .job_valid(!job_empty),
      .job      (head_job),
      .job_pop  (job_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_job_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (req_push && !req_full))
      else $error("frame judged without an accepted request");

   a_job_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (!job_full || job_pop))
      else $error("frame queue overflow");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> !job_empty)
      else $error("back end released a frame it did not hold");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("results present straight after reset");
`endif

endmodule
